@@ hdl/b64c_pkg.sv @@
package b64c_pkg;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;

    localparam int unsigned GROUP_BITS = 24;
    localparam int unsigned SHOWN_BITS = 24;

    // One queued job: up to four result bytes, how many of them, and the end flag.
    // A job with no bytes is only ever queued with the end flag and becomes the
    // end-only marker.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      num;
        logic            eom;
    } b64c_job_t;

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } b64c_sextet_t;

    function automatic logic [7:0] b64c_enc6(input logic [5:0] v);
        logic [7:0] c;
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            c = w + 8'h41;
        else if (v < 6'd52)
            c = w + 8'd71;
        else if (v < 6'd62)
            c = w - 8'd4;
        else if (v == 6'd62)
            c = CHAR_PLUS;
        else
            c = CHAR_SLASH;
        return c;
    endfunction

    function automatic b64c_sextet_t b64c_dec6(input logic [7:0] c);
        b64c_sextet_t s;
        logic [7:0]   t;
        s = '0;
        t = '0;
        case (c) inside
            [8'h41:8'h5A]:
            begin
                t = c - 8'h41;
                s.value = t[5:0];
            end
            [8'h61:8'h7A]:
            begin
                t = c - 8'd71;
                s.value = t[5:0];
            end
            [8'h30:8'h39]:
            begin
                t = c + 8'd4;
                s.value = t[5:0];
            end
            CHAR_PLUS:  s.value = 6'd62;
            CHAR_SLASH: s.value = 6'd63;
            CHAR_PAD:   s.value = 6'd0;
            default:    s.bad = 1'b1;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/b64c_front.sv @@
module b64c_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                direction,
    input  logic                clear,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                end_of_source,
    output logic                push,
    output b64c_pkg::b64c_job_t job
);
    import b64c_pkg::*;

    logic [GROUP_BITS-1:0] store_reg, store_next;
    logic [1:0]            fill_reg, fill_next;
    logic [1:0]            pad_reg, pad_next;
    logic                  stop_reg, stop_next;

    logic [GROUP_BITS-1:0] enc_shift;
    logic [GROUP_BITS-1:0] enc_group;
    logic [2:0]            held;
    logic [GROUP_BITS-1:0] dec_shift;
    logic [1:0]            pad_tmp;
    logic [2:0]            keep;
    b64c_sextet_t          sx;

    always_comb
    begin
        store_next = store_reg;
        fill_next  = fill_reg;
        pad_next   = pad_reg;
        stop_next  = stop_reg;
        job        = '0;
        enc_shift  = {store_reg[15:0], data_byte};
        held       = {1'b0, fill_reg} + 3'd1;
        enc_group  = enc_shift;
        sx         = b64c_dec6(data_byte);
        dec_shift  = {store_reg[17:0], sx.value};
        pad_tmp    = pad_reg;
        keep       = 3'd3;

        if (direction == DIR_ENCODE)
        begin
            if (held == 3'd1)
                enc_group = {enc_shift[7:0], 16'h0000};
            else if (held == 3'd2)
                enc_group = {enc_shift[15:0], 8'h00};
            if (held == 3'd3 || end_of_source)
            begin
                job.data[0] = b64c_enc6(enc_group[23:18]);
                job.data[1] = b64c_enc6(enc_group[17:12]);
                job.data[2] = (held < 3'd2) ? CHAR_PAD : b64c_enc6(enc_group[11:6]);
                job.data[3] = (held < 3'd3) ? CHAR_PAD : b64c_enc6(enc_group[5:0]);
                job.num     = 3'd4;
                store_next  = '0;
                fill_next   = '0;
            end
            else
            begin
                store_next = enc_shift;
                fill_next  = held[1:0];
            end
        end
        else if (!stop_reg)
        begin
            if (data_byte == CHAR_NUL)
            begin
                stop_next = 1'b1;
            end
            else if (!sx.bad)
            begin
                store_next = dec_shift;
                if (fill_reg == 2'd2 && data_byte == CHAR_PAD)
                    pad_tmp[0] = 1'b1;
                if (fill_reg == 2'd3)
                begin
                    if (data_byte == CHAR_PAD)
                        pad_tmp[1] = 1'b1;
                    keep = pad_tmp[0] ? 3'd1 : (pad_tmp[1] ? 3'd2 : 3'd3);
                    job.data[0] = dec_shift[23:16];
                    job.data[1] = dec_shift[15:8];
                    job.data[2] = dec_shift[7:0];
                    job.num     = keep;
                    store_next  = '0;
                    fill_next   = '0;
                    pad_tmp     = '0;
                    // Padding in a completed group ends the decoded output.
                    if (keep != 3'd3)
                        stop_next = 1'b1;
                end
                else
                begin
                    fill_next = fill_reg + 2'd1;
                end
                pad_next = pad_tmp;
            end
        end

        job.eom = end_of_source;
        if (end_of_source)
        begin
            store_next = '0;
            fill_next  = '0;
            pad_next   = '0;
            stop_next  = 1'b0;
        end
    end

    assign push = accept && (job.num != 3'd0 || end_of_source);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            fill_reg  <= '0;
            pad_reg   <= '0;
            stop_reg  <= 1'b0;
        end
        else if (clear)
        begin
            store_reg <= '0;
            fill_reg  <= '0;
            pad_reg   <= '0;
            stop_reg  <= 1'b0;
        end
        else if (accept)
        begin
            store_reg <= store_next;
            fill_reg  <= fill_next;
            pad_reg   <= pad_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

@@ hdl/b64c_queue.sv @@
module b64c_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64c_pkg::b64c_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output b64c_pkg::b64c_job_t head_job
);
    import b64c_pkg::*;

    b64c_job_t  slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] level_reg;

    assign full       = (level_reg == 2'd2);
    assign head_valid = (level_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                level_reg <= level_reg + 2'd1;
            else if (pop && !push)
                level_reg <= level_reg - 2'd1;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> level_reg == $past(level_reg) + 2'd1)
        else $error("queue level did not follow a lone write");
`endif

endmodule

@@ hdl/b64c_back.sv @@
module b64c_back #(
    parameter int COUNT_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                head_valid,
    input  b64c_pkg::b64c_job_t head_job,
    output logic                pop,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                last_of_run,
    output logic                end_of_message,
    output logic [23:0]         total_count
);
    import b64c_pkg::*;

    localparam int WIDE = (COUNT_BITS > SHOWN_BITS) ? COUNT_BITS : SHOWN_BITS;

    logic [1:0]            idx_reg, idx_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  valid_reg;
    logic [7:0]            byte_reg;
    logic                  bval_reg, last_reg, eom_reg;
    logic [23:0]           count_reg;

    logic                  emit;
    logic                  is_marker;
    logic                  is_last;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [WIDE-1:0]       cnt_wide;
    logic [23:0]           shown;

    assign emit      = head_valid && (!valid_reg || out_ready);
    assign is_marker = (head_job.num == 3'd0);
    assign is_last   = is_marker || ({1'b0, idx_reg} == head_job.num - 3'd1);
    assign pop       = emit && is_last;

    always_comb
    begin
        cnt_inc = cnt_reg;
        if (!is_marker && cnt_reg != {COUNT_BITS{1'b1}})
            cnt_inc = cnt_reg + COUNT_BITS'(1);
        cnt_wide = WIDE'(cnt_inc);
        shown    = (cnt_wide > WIDE'(24'hFFFFFF)) ? 24'hFFFFFF : cnt_wide[23:0];

        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (clear)
        begin
            cnt_next = '0;
            idx_next = '0;
        end
        else if (emit)
        begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
            // The count restarts once the final result of a message is out.
            cnt_next = (is_last && head_job.eom) ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            if (emit)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg  <= is_marker ? 8'h00 : head_job.data[idx_reg];
            bval_reg  <= !is_marker;
            last_reg  <= is_last;
            eom_reg   <= is_last && head_job.eom;
            count_reg <= shown;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign byte_valid     = bval_reg;
    assign last_of_run    = last_reg;
    assign end_of_message = eom_reg;
    assign total_count    = count_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && eom_reg) |-> last_reg)
        else $error("end of message shown without last of run");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !bval_reg) |-> (byte_reg == 8'h00 && eom_reg))
        else $error("end-only marker carries data or lacks end of message");
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_last && head_job.eom) |=> cnt_reg == '0)
        else $error("byte count not restarted after end of message");
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !is_last) |-> !pop)
        else $error("job released before its last result");
`endif

endmodule

@@ hdl/base64_codec_core.sv @@
// Streaming base64 codec with the standard alphabet. Each input transfer carries one byte with
// tlast marking the end of a message; the direction register selects encoding (0) or decoding
// (1), and writing it clears the front end's partial group and the emitter's position and count
// (queued jobs are kept). The front end accepts one input transfer per cycle whenever its
// two-entry job queue has room, and the result emitter drains that queue at one output transfer
// per cycle while the output is ready, so when encoding the output port sets the sustained rate.
// Results of an accepted input pass through the job queue and the output register. Output tlast
// marks the final result of a message, tuser is byte_valid, and an end-only marker (tuser low)
// appears when a message's last input produced no data.
module base64_codec_core #(
    parameter int COUNT_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // direction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] data_byte
    input  logic        s_tlast,        // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,        // [7:0] out_byte, [8] last_of_run, [32:9] total_count
    output logic        m_tuser,        // byte_valid
    output logic        m_tlast         // end_of_message
);
    import b64c_pkg::*;

    logic      direction_reg;
    logic      accept;
    logic      push;
    logic      full;
    logic      pop;
    logic      head_valid;
    b64c_job_t push_job;
    b64c_job_t head_job;

    logic [7:0]  out_byte;
    logic        last_of_run;
    logic [23:0] total_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            direction_reg <= DIR_ENCODE;
        else if (cfg_wr_en)
            direction_reg <= cfg_wr_data;
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    b64c_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .direction     (direction_reg),
        .clear         (cfg_wr_en),
        .accept        (accept),
        .data_byte     (s_tdata),
        .end_of_source (s_tlast),
        .push          (push),
        .job           (push_job)
    );

    b64c_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64c_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .clear          (cfg_wr_en),
        .head_valid     (head_valid),
        .head_job       (head_job),
        .pop            (pop),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_byte       (out_byte),
        .byte_valid     (m_tuser),
        .last_of_run    (last_of_run),
        .end_of_message (m_tlast),
        .total_count    (total_count)
    );

    assign m_tdata = {7'b0000000, total_count, last_of_run, out_byte};

endmodule
